// ===== design/ipl4_pkg.sv =====
// Shared types and constants for the IPv4 layer-4 header extractor.
// No dependencies; used by the top level and its checker.
package ipl4_pkg;

  // Frame geometry, in bytes from the first frame byte
  localparam logic [15:0] MAX_FRAME_LEN = 16'hFFFF;
  localparam logic [15:0] ETH_HDR_LEN   = 16'd14;
  localparam logic [15:0] MIN_IP_FRAME  = 16'd34;
  localparam logic [15:0] MIN_FRAME_RST = 16'd34;

  // IP header byte positions
  localparam logic [15:0] POS_VER_IHL   = 16'd14;
  localparam logic [15:0] POS_TLEN_HI   = 16'd16;
  localparam logic [15:0] POS_TLEN_LO   = 16'd17;
  localparam logic [15:0] POS_PROTO     = 16'd23;
  localparam logic [15:0] POS_SRC_FIRST = 16'd26;
  localparam logic [15:0] POS_SRC_LAST  = 16'd29;
  localparam logic [15:0] POS_DST_FIRST = 16'd30;
  localparam logic [15:0] POS_DST_LAST  = 16'd33;

  // Layer-4 byte positions relative to the layer-4 start
  localparam logic [15:0] L4_PORT_LAST  = 16'd3;
  localparam logic [15:0] L4_ULEN_HI    = 16'd4;
  localparam logic [15:0] L4_ULEN_LO    = 16'd5;
  localparam logic [15:0] L4_TCP_DOFF   = 16'd12;
  localparam logic [15:0] L4_TCP_FLAGS  = 16'd13;
  localparam logic [15:0] TCP_HDR_NEED  = 16'd14;
  localparam logic [15:0] UDP_HDR_NEED  = 16'd6;
  localparam logic [15:0] L4_FIXED_HDR  = 16'd8;

  localparam logic [3:0]  IP_VERSION4   = 4'd4;

  // IP protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Summary item; src_addr sits in the lowest bits of tdata
  typedef struct packed {
    logic [31:0] capture_seconds;
    logic [15:0] payload_length;
    logic [15:0] payload_offset;
    logic [7:0]  tcp_flag_bits;
    logic [15:0] dest_port;
    logic [15:0] source_port;
    logic [7:0]  ip_protocol;
    logic [31:0] dst_addr;
    logic [31:0] src_addr;
  } result_t;

  // Status flags carried on tuser
  typedef struct packed {
    logic header_truncated;
    logic length_underflow;
  } result_flags_t;

endpackage

// ===== design/ipv4_l4_header_extractor.sv =====
// IPv4 layer-4 header extractor: byte-stream frame parser with at most one summary per frame.
// Depends on ipl4_pkg.
//
// The item carrying tlast sets done; the summary is then loaded into the output register.
// Throughput: one item per cycle; input stalls only while a finished frame waits
// behind a summary held in the output register by a stalled receiver.
// Reset (rst, synchronous): byte counter, pending flags and output valid cleared,
// min_frame_len returns to 34.
module ipv4_l4_header_extractor (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic [15:0]  cfg_wdata,      // min_frame_len
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [39:0]  s_axis_tdata,   // [7:0] data_byte, [39:8] frame_time
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [175:0] m_axis_tdata,   // src_addr, dst_addr, ip_protocol, source port,
                                       // destination port, tcp_flag_bits, payload_offset,
                                       // payload_length, capture_seconds
  output logic [1:0]   m_axis_tuser    // [0] length_underflow, [1] header_truncated
);

  // Configuration register
  logic [15:0] min_frame_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_frame_len <= ipl4_pkg::MIN_FRAME_RST;
    end else if (cfg_wen) begin
      min_frame_len <= cfg_wdata;
    end
  end

  // Per-frame capture registers
  logic [15:0] byte_position, byte_position_next;
  logic [3:0]  header_words, header_words_next;
  logic        version_good, version_good_next;
  logic [15:0] total_length, total_length_next;
  logic [7:0]  proto_reg, proto_reg_next;
  logic [31:0] source_ip_reg, source_ip_reg_next;
  logic [31:0] dest_ip_reg, dest_ip_reg_next;
  logic [31:0] port_pair_reg, port_pair_reg_next;
  logic [7:0]  flags_reg, flags_reg_next;
  logic [3:0]  data_offset_words, data_offset_words_next;
  logic [15:0] datagram_length, datagram_length_next;
  logic [31:0] time_reg, time_reg_next;
  logic [15:0] frame_len, frame_len_next;
  logic        done;

  // Output register
  ipl4_pkg::result_t       out_data, out_data_next;
  ipl4_pkg::result_flags_t out_flags, out_flags_next;
  logic                    out_valid;
  logic                    out_load;

  // Pipeline advance: hold only when a summary is pending behind a stalled output
  logic adv;
  logic in_fire;

  assign adv           = !(done && out_valid && !m_axis_tready);
  assign s_axis_tready = adv;
  assign in_fire       = s_axis_tvalid && adv;

  // Byte capture logic
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        in_range;
  logic [15:0] l4_start;
  logic [15:0] l4_rel;

  assign data_byte = s_axis_tdata[7:0];

  always_comb begin
    first_byte = (byte_position == 16'd0);
    in_range   = (byte_position != ipl4_pkg::MAX_FRAME_LEN);

    // a new frame starts from cleared fields, with the frame time taken from its first byte
    header_words_next      = first_byte ? 4'd0  : header_words;
    version_good_next      = first_byte ? 1'b0  : version_good;
    total_length_next      = first_byte ? 16'd0 : total_length;
    proto_reg_next         = first_byte ? 8'd0  : proto_reg;
    source_ip_reg_next     = first_byte ? 32'd0 : source_ip_reg;
    dest_ip_reg_next       = first_byte ? 32'd0 : dest_ip_reg;
    port_pair_reg_next     = first_byte ? 32'd0 : port_pair_reg;
    flags_reg_next         = first_byte ? 8'd0  : flags_reg;
    data_offset_words_next = first_byte ? 4'd0  : data_offset_words;
    datagram_length_next   = first_byte ? 16'd0 : datagram_length;
    time_reg_next          = first_byte ? s_axis_tdata[39:8] : time_reg;

    l4_start = 16'd0;
    l4_rel   = 16'd0;

    if (in_range) begin
      // IP header fields at fixed positions
      if (byte_position == ipl4_pkg::POS_VER_IHL) begin
        version_good_next = (data_byte[7:4] == ipl4_pkg::IP_VERSION4);
        header_words_next = data_byte[3:0];
      end
      if (byte_position == ipl4_pkg::POS_TLEN_HI) total_length_next[15:8] = data_byte;
      if (byte_position == ipl4_pkg::POS_TLEN_LO) total_length_next[7:0]  = data_byte;
      if (byte_position == ipl4_pkg::POS_PROTO)   proto_reg_next          = data_byte;

      if (byte_position >= ipl4_pkg::POS_SRC_FIRST &&
          byte_position <= ipl4_pkg::POS_SRC_LAST) begin
        case (2'(byte_position - ipl4_pkg::POS_SRC_FIRST))
          2'd0:    source_ip_reg_next[31:24] = data_byte;
          2'd1:    source_ip_reg_next[23:16] = data_byte;
          2'd2:    source_ip_reg_next[15:8]  = data_byte;
          default: source_ip_reg_next[7:0]   = data_byte;
        endcase
      end
      if (byte_position >= ipl4_pkg::POS_DST_FIRST &&
          byte_position <= ipl4_pkg::POS_DST_LAST) begin
        case (2'(byte_position - ipl4_pkg::POS_DST_FIRST))
          2'd0:    dest_ip_reg_next[31:24] = data_byte;
          2'd1:    dest_ip_reg_next[23:16] = data_byte;
          2'd2:    dest_ip_reg_next[15:8]  = data_byte;
          default: dest_ip_reg_next[7:0]   = data_byte;
        endcase
      end

      // layer-4 fields; IHL read on this byte already applies to it
      l4_start = ipl4_pkg::ETH_HDR_LEN + {10'd0, header_words_next, 2'b00};
      if (byte_position >= l4_start) begin
        l4_rel = byte_position - l4_start;
        if (l4_rel <= ipl4_pkg::L4_PORT_LAST) begin
          case (l4_rel[1:0])
            2'd0:    port_pair_reg_next[31:24] = data_byte;
            2'd1:    port_pair_reg_next[23:16] = data_byte;
            2'd2:    port_pair_reg_next[15:8]  = data_byte;
            default: port_pair_reg_next[7:0]   = data_byte;
          endcase
        end
        if (l4_rel == ipl4_pkg::L4_ULEN_HI)   datagram_length_next[15:8] = data_byte;
        if (l4_rel == ipl4_pkg::L4_ULEN_LO)   datagram_length_next[7:0]  = data_byte;
        if (l4_rel == ipl4_pkg::L4_TCP_DOFF)  data_offset_words_next     = data_byte[7:4];
        if (l4_rel == ipl4_pkg::L4_TCP_FLAGS) flags_reg_next             = data_byte;
      end
    end

    // position counter saturates at the frame bound
    frame_len_next = in_range ? byte_position + 16'd1 : ipl4_pkg::MAX_FRAME_LEN;
    if (s_axis_tlast) begin
      byte_position_next = 16'd0;
    end else begin
      byte_position_next = in_range ? byte_position + 16'd1 : byte_position;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 16'd0;
      done          <= 1'b0;
    end else if (adv) begin
      done <= in_fire && s_axis_tlast;
      if (in_fire) begin
        byte_position <= byte_position_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      header_words      <= header_words_next;
      version_good      <= version_good_next;
      total_length      <= total_length_next;
      proto_reg         <= proto_reg_next;
      source_ip_reg     <= source_ip_reg_next;
      dest_ip_reg       <= dest_ip_reg_next;
      port_pair_reg     <= port_pair_reg_next;
      flags_reg         <= flags_reg_next;
      data_offset_words <= data_offset_words_next;
      datagram_length   <= datagram_length_next;
      time_reg          <= time_reg_next;
      frame_len         <= frame_len_next;
    end
  end

  // Summary computation from the finished frame's captures
  logic [15:0] ihl_bytes;
  logic [15:0] l4_base;
  logic [15:0] doff_bytes;
  logic [15:0] sub_a, sub_b;
  logic [16:0] sub_diff;
  logic        known_proto;
  logic        truncated;
  logic        emit;

  always_comb begin
    ihl_bytes  = {10'd0, header_words, 2'b00};
    l4_base    = ipl4_pkg::ETH_HDR_LEN + ihl_bytes;
    doff_bytes = {10'd0, data_offset_words, 2'b00};
    emit       = (frame_len >= min_frame_len) && version_good;

    out_data                 = '0;
    out_data.src_addr        = source_ip_reg;
    out_data.dst_addr        = dest_ip_reg;
    out_data.ip_protocol     = proto_reg;
    out_data.capture_seconds = time_reg;

    sub_a       = 16'd0;
    sub_b       = 16'd0;
    known_proto = 1'b0;
    truncated   = (frame_len < ipl4_pkg::MIN_IP_FRAME);

    case (proto_reg)
      ipl4_pkg::PROTO_TCP: begin
        known_proto = 1'b1;
        if (frame_len < l4_base + ipl4_pkg::TCP_HDR_NEED) truncated = 1'b1;
        out_data.source_port    = port_pair_reg[31:16];
        out_data.dest_port      = port_pair_reg[15:0];
        out_data.tcp_flag_bits  = flags_reg;
        out_data.payload_offset = l4_base + doff_bytes;
        sub_a = total_length;
        sub_b = ihl_bytes + doff_bytes;
      end
      ipl4_pkg::PROTO_UDP: begin
        known_proto = 1'b1;
        if (frame_len < l4_base + ipl4_pkg::UDP_HDR_NEED) truncated = 1'b1;
        out_data.source_port    = port_pair_reg[31:16];
        out_data.dest_port      = port_pair_reg[15:0];
        out_data.payload_offset = l4_base + ipl4_pkg::L4_FIXED_HDR;
        sub_a = datagram_length;
        sub_b = ipl4_pkg::L4_FIXED_HDR;
      end
      ipl4_pkg::PROTO_ICMP: begin
        known_proto = 1'b1;
        out_data.payload_offset = l4_base + ipl4_pkg::L4_FIXED_HDR;
        sub_a = total_length;
        sub_b = ihl_bytes + ipl4_pkg::L4_FIXED_HDR;
      end
      default: begin
        known_proto = 1'b0;
      end
    endcase

    // payload length clamps at zero
    sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
    out_flags.length_underflow = known_proto && sub_diff[16];
    out_flags.header_truncated = truncated;
    out_data.payload_length    = (known_proto && !sub_diff[16]) ? sub_diff[15:0] : 16'd0;

    // a truncated layer 4 reports no layer-4 fields
    if (truncated) begin
      out_data.source_port       = 16'd0;
      out_data.dest_port         = 16'd0;
      out_data.tcp_flag_bits     = 8'd0;
      out_data.payload_offset    = 16'd0;
      out_data.payload_length    = 16'd0;
      out_flags.length_underflow = 1'b0;
    end

    out_data_next  = out_data;
    out_flags_next = out_flags;
    out_load       = adv && done && emit;
  end

  // Output register
  ipl4_pkg::result_t       res_q;
  ipl4_pkg::result_flags_t flags_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_q   <= out_data_next;
      flags_q <= out_flags_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = res_q;
  assign m_axis_tuser  = flags_q;

endmodule

// ===== design/ipl4_checker.sv =====
// Port-level checker for the IPv4 layer-4 header extractor, with its bind.
// Depends on ipl4_pkg and the ports of ipv4_l4_header_extractor.
module ipl4_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [175:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  ipl4_pkg::result_t       res;
  ipl4_pkg::result_flags_t flg;

  assign res = m_axis_tdata;
  assign flg = m_axis_tuser;

  // a stalled summary keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("summary changed while stalled");

  // a new summary follows an accepted last item, through the done flag and the output register
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
    else $error("summary without a frame end");

  // input is never held off while the output register is empty
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // truncated frames report no layer-4 fields
  a_trunc_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && flg.header_truncated |->
      res.source_port == 16'd0 && res.dest_port == 16'd0 && res.tcp_flag_bits == 8'd0 &&
      res.payload_offset == 16'd0 && res.payload_length == 16'd0 && !flg.length_underflow)
    else $error("truncated summary carries layer-4 fields");

  // an underflow always reports a zero payload length
  a_uf_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && flg.length_underflow |-> res.payload_length == 16'd0)
    else $error("underflow with nonzero payload length");

endmodule

bind ipv4_l4_header_extractor ipl4_checker u_ipl4_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
